>>> hw/rtl/rswf_pkg.sv
// Shared types, constants and saturation helpers for the stereo wavefolder.
`default_nettype none

package rswf_pkg;

    localparam int SMP_BITS         = 24;
    localparam int RAMP_BITS        = 48;
    localparam int COEF_BITS        = 32;
    localparam int COEF_SHIFT       = SMP_BITS - 17;
    localparam int NUM_RAMPS        = 7;
    localparam int RAMP_IDX_BITS    = 3;
    localparam int FRAME_BITS       = 13;
    localparam int MAX_BLOCK_FRAMES = 4096;
    localparam int CFG_ADDR_BITS    = 3;
    localparam int CFG_DATA_BITS    = 32;
    localparam int DIV_BITS         = 50;
    localparam int DIV_MAG_BITS     = 49;
    localparam int DIV_CNT_BITS     = 6;
    localparam int MIX_BITS         = 17;
    localparam int LIN_BITS         = 31;

    localparam logic [MIX_BITS-1:0] MIX_ONE = 17'd65536;

    // Ramp slots
    localparam logic [RAMP_IDX_BITS-1:0] RAMP_MIX   = 3'd0;
    localparam logic [RAMP_IDX_BITS-1:0] RAMP_PRE   = 3'd1;
    localparam logic [RAMP_IDX_BITS-1:0] RAMP_DRIVE = 3'd2;
    localparam logic [RAMP_IDX_BITS-1:0] RAMP_LOW   = 3'd3;
    localparam logic [RAMP_IDX_BITS-1:0] RAMP_HIGH  = 3'd4;
    localparam logic [RAMP_IDX_BITS-1:0] RAMP_POST  = 3'd5;
    localparam logic [RAMP_IDX_BITS-1:0] RAMP_GAIN  = 3'd6;

    // Configuration register indexes
    localparam logic [CFG_ADDR_BITS-1:0] CFG_MIX   = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_PRE   = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_DRIVE = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_LOW   = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_HIGH  = 3'd4;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_GAIN  = 3'd5;

    localparam logic signed [DIV_BITS-1:0] WIDE_LIM = 50'sd70368744177663;
    localparam logic signed [DIV_BITS-1:0] R48_MAX  = 50'sd140737488355327;

    typedef struct packed {
        logic                       kind;
        logic                       mono;
        logic signed [SMP_BITS-1:0] left_in;
        logic signed [SMP_BITS-1:0] right_in;
        logic [FRAME_BITS-1:0]      frames;
    } rswf_in_t;

    typedef struct packed {
        logic signed [SMP_BITS-1:0] left_out;
        logic signed [SMP_BITS-1:0] right_out;
    } rswf_out_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_PRE, ST_DRIVE, ST_DRIVE_W, ST_FOLD_HI, ST_FOLD_LO, ST_POST,
        ST_GAIN, ST_GAIN_W, ST_MIX, ST_MIX_W, ST_RAMP, ST_OUT, ST_BS_RAMP, ST_BS_WAIT
    } rswf_state_t;

    typedef enum logic [1:0] {MUL_IDLE, MUL_LO, MUL_HI, MUL_SUM} rswf_mul_state_t;

    typedef enum logic [1:0] {DIV_IDLE, DIV_RUN, DIV_FIN} rswf_div_state_t;

    // Saturate to +-(2^46 - 1)
    function automatic logic signed [RAMP_BITS-1:0] sat_wide(
        input logic signed [DIV_BITS-1:0] v);
        logic signed [RAMP_BITS-1:0] r;
        if (v > WIDE_LIM) begin
            r = WIDE_LIM[RAMP_BITS-1:0];
        end else if (v < -WIDE_LIM) begin
            r = -WIDE_LIM[RAMP_BITS-1:0];
        end else begin
            r = v[RAMP_BITS-1:0];
        end
        return r;
    endfunction

    // Saturate to the 48 bit ramp range
    function automatic logic signed [RAMP_BITS-1:0] sat_ramp(
        input logic signed [DIV_BITS-1:0] v);
        logic signed [RAMP_BITS-1:0] r;
        if (v > R48_MAX) begin
            r = R48_MAX[RAMP_BITS-1:0];
        end else if (v < -R48_MAX - 50'sd1) begin
            r = {1'b1, {(RAMP_BITS-1){1'b0}}};
        end else begin
            r = v[RAMP_BITS-1:0];
        end
        return r;
    endfunction

    // Saturate a wide word to a sample
    function automatic logic signed [SMP_BITS-1:0] sat_smp(
        input logic signed [RAMP_BITS-1:0] v);
        logic signed [SMP_BITS-1:0] r;
        if (v > $signed({{(RAMP_BITS-SMP_BITS+1){1'b0}}, {(SMP_BITS-1){1'b1}}})) begin
            r = {1'b0, {(SMP_BITS-1){1'b1}}};
        end else if (v < $signed({{(RAMP_BITS-SMP_BITS+1){1'b1}}, {(SMP_BITS-1){1'b0}}})) begin
            r = {1'b1, {(SMP_BITS-1){1'b0}}};
        end else begin
            r = v[SMP_BITS-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/rswf_mul.sv
// Shared coefficient multiplier: 48 bit word times Q16.16, floored and saturated.
`default_nettype none

module rswf_mul (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  start,
    input  wire logic signed [rswf_pkg::RAMP_BITS-1:0] a,
    input  wire logic signed [rswf_pkg::COEF_BITS-1:0] c,
    output logic                                       done,
    output logic signed [rswf_pkg::RAMP_BITS-1:0]      y
);
    import rswf_pkg::*;

    localparam int HALF = RAMP_BITS / 2;
    localparam int PW   = HALF + 1 + COEF_BITS;
    localparam int SW   = PW + HALF + 1;
    localparam logic signed [SW-17:0] LIM = 66'sd70368744177663;

    rswf_mul_state_t state_reg, state_next;
    logic signed [RAMP_BITS-1:0] a_reg;
    logic signed [COEF_BITS-1:0] c_reg;
    logic signed [PW-1:0]        prod_reg;
    logic signed [PW-1:0]        acc_reg;
    logic signed [HALF:0]        opa;
    logic signed [PW-1:0]        prod;
    logic signed [SW-1:0]        sum;
    logic signed [SW-17:0]       shifted;
    logic signed [RAMP_BITS-1:0] y_reg;
    logic                        done_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            MUL_IDLE: if (start) state_next = MUL_LO;
            MUL_LO:   state_next = MUL_HI;
            MUL_HI:   state_next = MUL_SUM;
            MUL_SUM:  state_next = MUL_IDLE;
            default:  state_next = MUL_IDLE;
        endcase
    end

    // Operand select: low half unsigned, high half signed
    always_comb begin
        unique case (state_reg)
            MUL_LO:  opa = $signed({1'b0, a_reg[HALF-1:0]});
            default: opa = $signed({a_reg[RAMP_BITS-1], a_reg[RAMP_BITS-1:HALF]});
        endcase
    end

    assign prod    = opa * c_reg;
    assign sum     = $signed({{(HALF+1){acc_reg[PW-1]}}, acc_reg})
                   + $signed({prod_reg[PW-1], prod_reg, {HALF{1'b0}}});
    assign shifted = sum[SW-1:16];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MUL_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == MUL_SUM);
        end
    end

    // Accumulate partial products
    always_ff @(posedge aclk) begin
        if (state_reg == MUL_IDLE && start) begin
            a_reg <= a;
            c_reg <= c;
        end
        if (state_reg == MUL_LO || state_reg == MUL_HI) begin
            prod_reg <= prod;
        end
        if (state_reg == MUL_HI) begin
            acc_reg <= prod_reg;
        end
        if (state_reg == MUL_SUM) begin
            if (shifted > LIM) begin
                y_reg <= LIM[RAMP_BITS-1:0];
            end else if (shifted < -LIM) begin
                y_reg <= -LIM[RAMP_BITS-1:0];
            end else begin
                y_reg <= shifted[RAMP_BITS-1:0];
            end
        end
    end

    assign done = done_reg;
    assign y    = y_reg;

endmodule

`default_nettype wire

>>> hw/rtl/rswf_div.sv
// Radix-2 restoring divider for ramp steps, truncating toward zero, saturated.
`default_nettype none

module rswf_div (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 start,
    input  wire logic signed [rswf_pkg::DIV_BITS-1:0] dividend,
    input  wire logic [rswf_pkg::FRAME_BITS-1:0]      divisor,
    output logic                                      done,
    output logic signed [rswf_pkg::RAMP_BITS-1:0]     quotient
);
    import rswf_pkg::*;

    rswf_div_state_t state_reg, state_next;
    logic                       neg_reg;
    logic [DIV_MAG_BITS-1:0]    mag_reg;
    logic [FRAME_BITS-1:0]      dvs_reg;
    logic [FRAME_BITS-1:0]      rem_reg;
    logic [DIV_CNT_BITS-1:0]    cnt_reg;
    logic signed [RAMP_BITS-1:0] q_reg;
    logic                       done_reg;
    logic signed [DIV_BITS-1:0] abs_in;
    logic [FRAME_BITS:0]        trial;
    logic [FRAME_BITS:0]        diff;
    logic                       ge;
    logic signed [DIV_BITS-1:0] q_signed;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            DIV_IDLE: if (start) state_next = DIV_RUN;
            DIV_RUN:  if (cnt_reg == DIV_CNT_BITS'(1)) state_next = DIV_FIN;
            DIV_FIN:  state_next = DIV_IDLE;
            default:  state_next = DIV_IDLE;
        endcase
    end

    // One quotient bit per cycle
    always_comb begin
        abs_in   = dividend[DIV_BITS-1] ? -dividend : dividend;
        trial    = {rem_reg, mag_reg[DIV_MAG_BITS-1]};
        diff     = trial - {1'b0, dvs_reg};
        ge       = (trial >= {1'b0, dvs_reg});
        q_signed = neg_reg ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DIV_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == DIV_FIN);
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            DIV_IDLE: begin
                if (start) begin
                    neg_reg <= dividend[DIV_BITS-1];
                    mag_reg <= abs_in[DIV_MAG_BITS-1:0];
                    dvs_reg <= divisor;
                    rem_reg <= '0;
                    cnt_reg <= DIV_CNT_BITS'(DIV_MAG_BITS);
                end
            end
            DIV_RUN: begin
                rem_reg <= ge ? diff[FRAME_BITS-1:0] : trial[FRAME_BITS-1:0];
                mag_reg <= {mag_reg[DIV_MAG_BITS-2:0], ge};
                cnt_reg <= cnt_reg - DIV_CNT_BITS'(1);
            end
            DIV_FIN: begin
                q_reg <= sat_ramp(q_signed);
            end
            default: begin
            end
        endcase
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

>>> hw/rtl/ramped_stereo_wavefolder_core.sv
// Stereo wavefolder top level: sequencer, ramp registers and output register.
//
// Input words on s_* (valid/ready) are either audio frames (kind 0) or block
// starts (kind 1). A frame yields one word on m_*; a block start yields none.
// Configuration registers are written on cfg_wr_en with cfg_addr/cfg_wdata and
// take effect at the next block start.
// One shared multiplier (three phases) handles drive, gain and mix, one
// channel after the other. Each frame ends with an update of all 7 ramps.
// A block start with zero frames sets each of the 7 ramps to its target with
// a zero step; otherwise each ramp runs a 49 step serial divide for its step.
// s_ready is high only while the sequencer is idle. The finished frame sits in
// an output register, so the next word is taken while it waits; a frame that
// finishes while the receiver stalls holds in the sequencer until the output
// register frees up.
// Reset (aresetn, synchronous, active low) zeroes all ramps and steps, loads
// the register defaults and empties the output register.
`default_nettype none

module ramped_stereo_wavefolder_core (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire rswf_pkg::rswf_in_t                  s_data,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output rswf_pkg::rswf_out_t                      m_data,
    input  wire logic                                cfg_wr_en,
    input  wire logic [rswf_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
    input  wire logic [rswf_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
    import rswf_pkg::*;

    rswf_state_t state_reg, state_next;

    // Configuration
    logic [MIX_BITS-1:0]         mix_reg;
    logic signed [COEF_BITS-1:0] pre_reg;
    logic [LIN_BITS-1:0]         drive_reg;
    logic signed [COEF_BITS-1:0] low_reg;
    logic signed [COEF_BITS-1:0] high_reg;
    logic [LIN_BITS-1:0]         gain_reg;

    // Ramps
    logic signed [RAMP_BITS-1:0] ramp_value_reg [NUM_RAMPS];
    logic signed [RAMP_BITS-1:0] ramp_step_reg  [NUM_RAMPS];

    // Datapath
    logic                        mono_reg;
    logic                        ch_reg;
    logic signed [SMP_BITS-1:0]  x_reg;
    logic signed [SMP_BITS-1:0]  right_reg;
    logic signed [RAMP_BITS-1:0] d_reg;
    logic                        folded_reg;
    logic signed [SMP_BITS-1:0]  l_res_reg;
    logic signed [SMP_BITS-1:0]  r_res_reg;
    logic [FRAME_BITS-1:0]       frames_reg;
    logic [RAMP_IDX_BITS-1:0]    cnt_reg;
    logic                        m_valid_reg;
    rswf_out_t                   m_data_reg;

    logic [RAMP_IDX_BITS-1:0]    rd_idx;
    logic                        mul_start;
    logic signed [RAMP_BITS-1:0] mul_a;
    logic                        mul_done;
    logic signed [RAMP_BITS-1:0] mul_y;
    logic                        div_start;
    logic                        div_done;
    logic signed [RAMP_BITS-1:0] div_q;

    logic signed [COEF_BITS-1:0] coef;
    logic signed [RAMP_BITS-1:0] coef48;
    logic signed [RAMP_BITS-1:0] x48;
    logic signed [RAMP_BITS-1:0] d_minus_x;
    logic signed [RAMP_BITS-1:0] fold_lo_val;
    logic signed [SMP_BITS-1:0]  mix_res;
    logic signed [RAMP_BITS-1:0] ramp_sum;
    logic [MIX_BITS-1:0]         mix_c;
    logic signed [COEF_BITS-1:0] lo_o;
    logic signed [COEF_BITS-1:0] hi_o;
    logic signed [COEF_BITS:0]   mid_sum;
    logic signed [RAMP_BITS-1:0] tgt;
    logic signed [DIV_BITS-1:0]  tgt_diff;
    logic                        in_acc;
    logic                        out_free;

    assign in_acc   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) state_next = s_data.kind ? ST_BS_RAMP : ST_PRE;
            end
            ST_PRE:     state_next = ST_DRIVE;
            ST_DRIVE:   state_next = ST_DRIVE_W;
            ST_DRIVE_W: if (mul_done) state_next = ST_FOLD_HI;
            ST_FOLD_HI: state_next = ST_FOLD_LO;
            ST_FOLD_LO: state_next = ST_POST;
            ST_POST:    state_next = ST_GAIN;
            ST_GAIN:    state_next = ST_GAIN_W;
            ST_GAIN_W:  if (mul_done) state_next = ST_MIX;
            ST_MIX:     state_next = ST_MIX_W;
            ST_MIX_W: begin
                if (mul_done) state_next = (!ch_reg && !mono_reg) ? ST_PRE : ST_RAMP;
            end
            ST_RAMP:    if (cnt_reg == RAMP_GAIN) state_next = ST_OUT;
            ST_OUT:     if (out_free) state_next = ST_IDLE;
            ST_BS_RAMP: begin
                if (frames_reg != '0) begin
                    state_next = ST_BS_WAIT;
                end else if (cnt_reg == RAMP_GAIN) begin
                    state_next = ST_IDLE;
                end
            end
            ST_BS_WAIT: begin
                if (div_done) state_next = (cnt_reg == RAMP_GAIN) ? ST_IDLE : ST_BS_RAMP;
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_ready   = 1'b0;
        rd_idx    = cnt_reg;
        mul_start = 1'b0;
        mul_a     = d_reg;
        div_start = 1'b0;
        unique case (state_reg)
            ST_IDLE:    s_ready = 1'b1;
            ST_PRE:     rd_idx = RAMP_PRE;
            ST_DRIVE: begin
                rd_idx    = RAMP_DRIVE;
                mul_start = 1'b1;
            end
            ST_FOLD_HI: rd_idx = RAMP_HIGH;
            ST_FOLD_LO: rd_idx = RAMP_LOW;
            ST_POST:    rd_idx = RAMP_POST;
            ST_GAIN: begin
                rd_idx    = RAMP_GAIN;
                mul_start = 1'b1;
            end
            ST_MIX: begin
                rd_idx    = RAMP_MIX;
                mul_start = 1'b1;
                mul_a     = d_minus_x;
            end
            ST_BS_RAMP: div_start = (frames_reg != '0);
            default: begin
            end
        endcase
    end

    // Coefficient and sample words
    always_comb begin
        coef        = ramp_value_reg[rd_idx][RAMP_BITS-1:16];
        coef48      = {{(RAMP_BITS-COEF_BITS-COEF_SHIFT){coef[COEF_BITS-1]}}, coef,
                       {COEF_SHIFT{1'b0}}};
        x48         = {{(RAMP_BITS-SMP_BITS){x_reg[SMP_BITS-1]}}, x_reg};
        d_minus_x   = d_reg - x48;
        fold_lo_val = (!folded_reg && d_reg < coef48) ? (coef48 <<< 1) - d_reg : d_reg;
        mix_res     = sat_smp(x48 + mul_y);
        ramp_sum    = sat_ramp(DIV_BITS'(ramp_value_reg[cnt_reg])
                               + DIV_BITS'(ramp_step_reg[cnt_reg]));
    end

    // Block targets
    always_comb begin
        mix_c   = (mix_reg > MIX_ONE) ? MIX_ONE : mix_reg;
        lo_o    = (low_reg > high_reg) ? high_reg : low_reg;
        hi_o    = (low_reg > high_reg) ? low_reg : high_reg;
        mid_sum = (COEF_BITS+1)'(lo_o) + (COEF_BITS+1)'(hi_o);
        case (cnt_reg)
            RAMP_MIX:   tgt = RAMP_BITS'({mix_c, 16'd0});
            RAMP_PRE:   tgt = {pre_reg, 16'd0};
            RAMP_DRIVE: tgt = {1'b0, drive_reg, 16'd0};
            RAMP_LOW:   tgt = {lo_o, 16'd0};
            RAMP_HIGH:  tgt = {hi_o, 16'd0};
            RAMP_POST:  tgt = (lo_o == hi_o) ? '0 : {mid_sum, 15'd0};
            default:    tgt = {1'b0, gain_reg, 16'd0};
        endcase
        tgt_diff = DIV_BITS'(tgt) - DIV_BITS'(ramp_value_reg[cnt_reg]);
    end

    rswf_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .c       (coef),
        .done    (mul_done),
        .y       (mul_y)
    );

    rswf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (tgt_diff),
        .divisor  (frames_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // Control, configuration and ramps
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
            mix_reg     <= MIX_ONE;
            pre_reg     <= '0;
            drive_reg   <= LIN_BITS'(65536);
            low_reg     <= -32'sd65536;
            high_reg    <= 32'sd65536;
            gain_reg    <= LIN_BITS'(65536);
            for (int i = 0; i < NUM_RAMPS; i++) begin
                ramp_value_reg[i] <= '0;
                ramp_step_reg[i]  <= '0;
            end
        end else begin
            state_reg <= state_next;

            // Register writes
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_MIX:   mix_reg   <= cfg_wdata[MIX_BITS-1:0];
                    CFG_PRE:   pre_reg   <= cfg_wdata;
                    CFG_DRIVE: drive_reg <= cfg_wdata[LIN_BITS-1:0];
                    CFG_LOW:   low_reg   <= cfg_wdata;
                    CFG_HIGH:  high_reg  <= cfg_wdata;
                    CFG_GAIN:  gain_reg  <= cfg_wdata[LIN_BITS-1:0];
                    default: begin
                    end
                endcase
            end

            // Output register: load a finished frame, else drop a taken word
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            // Ramp index and updates
            case (state_reg)
                ST_IDLE: cnt_reg <= '0;
                ST_MIX_W: cnt_reg <= '0;
                ST_RAMP: begin
                    ramp_value_reg[cnt_reg] <= ramp_sum;
                    cnt_reg <= cnt_reg + RAMP_IDX_BITS'(1);
                end
                ST_BS_RAMP: begin
                    if (frames_reg == '0) begin
                        ramp_value_reg[cnt_reg] <= tgt;
                        ramp_step_reg[cnt_reg]  <= '0;
                        cnt_reg <= cnt_reg + RAMP_IDX_BITS'(1);
                    end
                end
                ST_BS_WAIT: begin
                    if (div_done) begin
                        ramp_step_reg[cnt_reg] <= div_q;
                        cnt_reg <= cnt_reg + RAMP_IDX_BITS'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Sample path
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    mono_reg  <= s_data.mono;
                    ch_reg    <= 1'b0;
                    x_reg     <= s_data.left_in;
                    right_reg <= s_data.right_in;
                    frames_reg <= (s_data.frames > FRAME_BITS'(MAX_BLOCK_FRAMES))
                                  ? FRAME_BITS'(MAX_BLOCK_FRAMES) : s_data.frames;
                end
            end
            ST_PRE:     d_reg <= x48 + coef48;
            ST_DRIVE_W: if (mul_done) d_reg <= mul_y;
            ST_FOLD_HI: begin
                folded_reg <= (d_reg > coef48);
                if (d_reg > coef48) d_reg <= (coef48 <<< 1) - d_reg;
            end
            ST_FOLD_LO: d_reg <= sat_wide(DIV_BITS'(fold_lo_val));
            ST_POST:    d_reg <= sat_wide(DIV_BITS'(d_reg) - DIV_BITS'(coef48));
            ST_GAIN_W:  if (mul_done) d_reg <= mul_y;
            ST_MIX_W: begin
                if (mul_done) begin
                    if (!ch_reg) begin
                        l_res_reg <= mix_res;
                        r_res_reg <= mix_res;
                        ch_reg    <= 1'b1;
                        x_reg     <= right_reg;
                    end else begin
                        r_res_reg <= mix_res;
                    end
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_data_reg.left_out  <= l_res_reg;
                    m_data_reg.right_out <= r_res_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

>>> sim/tb_ramped_stereo_wavefolder_core.sv
// Self-checking testbench for the ramped stereo wavefolder core.
`timescale 1ns / 1ps

module tb_ramped_stereo_wavefolder_core;
    import rswf_pkg::*;

    localparam longint FOLD_LIM  = (64'sd1 <<< 46) - 1;
    localparam longint RAMP_HI   = (64'sd1 <<< 47) - 1;
    localparam longint RAMP_LO   = -(64'sd1 <<< 47);
    localparam longint SMP_MAX   = (64'sd1 <<< (SMP_BITS - 1)) - 1;
    localparam longint SMP_MIN   = -(64'sd1 <<< (SMP_BITS - 1));
    localparam int     SETTLE    = 500;
    localparam int     N_PHASES  = 6;
    localparam int     PHASE_LEN = 172;
    localparam int     QUIET_LEN = 150;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_SPARE_B = 3'd7;
    localparam bit KIND_FRAME = 1'b0;
    localparam bit KIND_BLOCK = 1'b1;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    rswf_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    rswf_out_t m_data;
    logic      cfg_wr_en = 1'b0;
    logic [CFG_ADDR_BITS-1:0] cfg_addr = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

    ramped_stereo_wavefolder_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Shadow of the block: registers and ramps
    logic [31:0] shadow_reg [6];
    longint      ramp_val [NUM_RAMPS];
    longint      ramp_stp [NUM_RAMPS];
    rswf_out_t   pending_out [$];
    int          fail_cnt = 0;
    bit          quiet = 1'b0;

    function automatic longint clamp64(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint coef_of(int i);
        return ramp_val[i] >>> 16;
    endfunction

    // Q16.16 coefficient times wide sample, floored and saturated
    function automatic longint mul_q16(longint a, longint c);
        longint unsigned ua, uc;
        bit neg;
        ua  = a < 0 ? -a : a;
        uc  = c < 0 ? -c : c;
        neg = (a < 0) != (c < 0);
        if (uc != 0 && ua > ((64'd1 << 62) / uc))
            return neg ? -FOLD_LIM : FOLD_LIM;
        return clamp64((a * c) >>> 16, -FOLD_LIM, FOLD_LIM);
    endfunction

    function automatic longint fold_sample(longint x);
        longint hi, lo, d;
        hi = coef_of(RAMP_HIGH) * 128;
        lo = coef_of(RAMP_LOW) * 128;
        d  = mul_q16(x + coef_of(RAMP_PRE) * 128, coef_of(RAMP_DRIVE));
        if (d > hi)
            d = 2 * hi - d;
        else if (d < lo)
            d = 2 * lo - d;
        d = clamp64(d, -FOLD_LIM, FOLD_LIM);
        d = clamp64(d - coef_of(RAMP_POST) * 128, -FOLD_LIM, FOLD_LIM);
        d = mul_q16(d, coef_of(RAMP_GAIN));
        d = x + mul_q16(d - x, coef_of(RAMP_MIX));
        return clamp64(d, SMP_MIN, SMP_MAX);
    endfunction

    // Order bounds, derive targets, set ramp steps or jump
    function automatic void start_block(int frames);
        longint tgt [NUM_RAMPS];
        longint mix, lo, hi, t;
        mix = longint'(shadow_reg[CFG_MIX][16:0]);
        lo  = longint'($signed(shadow_reg[CFG_LOW]));
        hi  = longint'($signed(shadow_reg[CFG_HIGH]));
        if (mix > 65536) mix = 65536;
        if (lo > hi) begin
            t = lo; lo = hi; hi = t;
        end
        tgt[RAMP_MIX]   = mix * 65536;
        tgt[RAMP_PRE]   = longint'($signed(shadow_reg[CFG_PRE])) * 65536;
        tgt[RAMP_DRIVE] = longint'(shadow_reg[CFG_DRIVE][30:0]) * 65536;
        tgt[RAMP_LOW]   = lo * 65536;
        tgt[RAMP_HIGH]  = hi * 65536;
        tgt[RAMP_POST]  = (lo == hi) ? 0 : (lo + hi) * 32768;
        tgt[RAMP_GAIN]  = longint'(shadow_reg[CFG_GAIN][30:0]) * 65536;
        if (frames > MAX_BLOCK_FRAMES) frames = MAX_BLOCK_FRAMES;
        for (int i = 0; i < NUM_RAMPS; i++) begin
            if (frames == 0) begin
                ramp_val[i] = tgt[i];
                ramp_stp[i] = 0;
            end else begin
                ramp_stp[i] = clamp64((tgt[i] - ramp_val[i]) / longint'(frames),
                                      RAMP_LO, RAMP_HI);
            end
        end
    endfunction

    // Predict one word; returns 1 when a result is due
    function automatic bit fold_word(rswf_in_t w, output rswf_out_t res);
        longint l, r;
        res = '0;
        if (w.kind == KIND_BLOCK) begin
            start_block(int'(w.frames));
            return 1'b0;
        end
        l = fold_sample(longint'(w.left_in));
        r = w.mono ? l : fold_sample(longint'(w.right_in));
        res.left_out  = l[SMP_BITS-1:0];
        res.right_out = r[SMP_BITS-1:0];
        for (int i = 0; i < NUM_RAMPS; i++)
            ramp_val[i] = clamp64(ramp_val[i] + ramp_stp[i], RAMP_LO, RAMP_HI);
        return 1'b1;
    endfunction

    // Receiver stalls in random bursts
    int stall_cnt = 0;
    always @(posedge aclk) begin
        if (stall_cnt > 0) begin
            stall_cnt <= stall_cnt - 1;
        end else if (quiet) begin
            m_ready <= 1'b1;
        end else begin
            m_ready   <= ($urandom_range(0, 2) != 0);
            stall_cnt <= $urandom_range(1, 9);
        end
    end

    // Compare each output word with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_out.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= 10)
                    $display("ERROR: unexpected output word L=%0d R=%0d",
                             m_data.left_out, m_data.right_out);
            end else begin
                if (m_data.left_out !== pending_out[0].left_out ||
                    m_data.right_out !== pending_out[0].right_out) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("ERROR: expected L=%0d R=%0d, got L=%0d R=%0d",
                                 pending_out[0].left_out, pending_out[0].right_out,
                                 m_data.left_out, m_data.right_out);
                end
                void'(pending_out.pop_front());
            end
        end
    end

    // Hold valid until the word is taken
    task automatic send_word(rswf_in_t w);
        rswf_out_t res;
        s_data  <= w;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        if (fold_word(w, res)) pending_out.push_back(res);
    endtask

    task automatic pause_sender(int n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    // Drain all results, then let a block start finish
    task automatic drain_all();
        s_valid <= 1'b0;
        while (pending_out.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_regs(logic [31:0] vals [6], bit spare);
        for (int i = 0; i < 6; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= CFG_ADDR_BITS'(i);
            cfg_wdata <= vals[i];
            shadow_reg[i] = vals[i];
            @(posedge aclk);
        end
        // Out of range indexes must be ignored
        if (spare) begin
            cfg_addr  <= CFG_SPARE_A;
            cfg_wdata <= $urandom();
            @(posedge aclk);
            cfg_addr  <= CFG_SPARE_B;
            cfg_wdata <= $urandom();
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_reg(int idx);
        bit wide;
        wide = ($urandom_range(0, 3) == 0);
        case (idx)
            CFG_MIX:   return $urandom_range(0, 131071);
            CFG_DRIVE: return wide ? ($urandom() >> 1) : $urandom_range(0, 6 * 65536);
            CFG_GAIN:  return wide ? ($urandom() >> 1) : $urandom_range(0, 3 * 65536);
            CFG_PRE:   return wide ? $urandom() : $urandom_range(0, 65536) - 32768;
            default:   return wide ? $urandom() : $urandom_range(0, 4 * 65536) - 2 * 65536;
        endcase
    endfunction

    function automatic rswf_in_t random_word();
        rswf_in_t w;
        int sel;
        w.kind     = KIND_FRAME;
        w.mono     = ($urandom_range(0, 9) < 3);
        w.left_in  = SMP_BITS'($urandom());
        w.right_in = SMP_BITS'($urandom());
        w.frames   = FRAME_BITS'($urandom());
        sel = $urandom_range(0, 99);
        if (sel < 15) begin
            w.kind = KIND_BLOCK;
            sel = $urandom_range(0, 99);
            if (sel < 70)      w.frames = FRAME_BITS'($urandom_range(1, 16));
            else if (sel < 80) w.frames = '0;
            else if (sel < 95) w.frames = FRAME_BITS'($urandom_range(17, MAX_BLOCK_FRAMES));
            else               w.frames = FRAME_BITS'($urandom_range(MAX_BLOCK_FRAMES + 1,
                                                                     8191));
        end
        return w;
    endfunction

    // Directed words; typed results hold while every ramp is still zero
    typedef struct {
        bit kind;
        bit mono;
        int left;
        int right;
        int frames;
        bit typed;
        int exp_left;
        int exp_right;
    } stim_row_t;

    stim_row_t directed [] = '{
        '{KIND_FRAME, 0,  8388607, -8388608, 0,    1,  8388607, -8388608},
        '{KIND_FRAME, 1, -8388608,  8388607, 8191, 1, -8388608, -8388608},
        '{KIND_FRAME, 0,        0,       -1, 0,    1,        0,       -1},
        '{KIND_FRAME, 1,  4194304,  1234567, 0,    1,  4194304,  4194304},
        '{KIND_BLOCK, 0,        0,        0, 0,    0, 0, 0},
        '{KIND_FRAME, 0,  8388607, -8388608, 0,    0, 0, 0},
        '{KIND_FRAME, 0,  6000000, -6000000, 0,    0, 0, 0},
        '{KIND_FRAME, 1,  -300000,   777777, 0,    0, 0, 0},
        '{KIND_BLOCK, 1, -1,  1, 4096,  0, 0, 0},
        '{KIND_FRAME, 0,  8388607,        1, 0,    0, 0, 0},
        '{KIND_BLOCK, 0,  0, 0, 8191,  0, 0, 0},
        '{KIND_FRAME, 0, -8388608,  8388607, 0,    0, 0, 0},
        '{KIND_BLOCK, 0,  0, 0, 1,     0, 0, 0},
        '{KIND_FRAME, 0,  2000000, -2000000, 0,    0, 0, 0},
        '{KIND_FRAME, 1,  8388607,        0, 0,    0, 0, 0}
    };

    // Main sequence
    initial begin
        logic [31:0] vals [6];
        rswf_in_t    w;
        rswf_out_t   res;
        shadow_reg = '{32'd65536, 32'd0, 32'd65536, 32'hFFFF0000, 32'd65536, 32'd65536};
        for (int i = 0; i < NUM_RAMPS; i++) begin
            ramp_val[i] = 0;
            ramp_stp[i] = 0;
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Walk the directed table
        foreach (directed[i]) begin
            w.kind     = directed[i].kind;
            w.mono     = directed[i].mono;
            w.left_in  = SMP_BITS'(directed[i].left);
            w.right_in = SMP_BITS'(directed[i].right);
            w.frames   = FRAME_BITS'(directed[i].frames);
            s_data  <= w;
            s_valid <= 1'b1;
            do @(posedge aclk); while (!s_ready);
            if (fold_word(w, res)) begin
                if (directed[i].typed) begin
                    res.left_out  = SMP_BITS'(directed[i].exp_left);
                    res.right_out = SMP_BITS'(directed[i].exp_right);
                end
                pending_out.push_back(res);
            end
        end

        // Random phases, each under its own register setting
        for (int p = 0; p < N_PHASES; p++) begin
            drain_all();
            case (p)
                0: vals = '{32'd131071, 32'h80000000, 32'h7FFFFFFF,
                            32'd131072, 32'hFFFE0000, 32'h7FFFFFFF};
                1: vals = '{32'd0, 32'h7FFFFFFF, 32'd0, 32'd12345, 32'd12345, 32'd0};
                2: vals = '{32'd65536, 32'd0, 32'd262144, 32'hFFFF8000,
                            32'd32768, 32'd65536};
                default:
                    for (int i = 0; i < 6; i++) vals[i] = pick_reg(i);
            endcase
            write_regs(vals, p == 0);
            for (int n = 0; n < PHASE_LEN; n++) begin
                if (p == N_PHASES - 1 && n == PHASE_LEN - QUIET_LEN) quiet = 1'b1;
                if (!quiet && $urandom_range(0, 3) == 0)
                    pause_sender($urandom_range(1, 9));
                send_word(random_word());
            end
        end

        drain_all();
        if (fail_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Hard stop on a hung handshake
    initial begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
